// ===== rtl/bhs_pkg.sv =====
// Package for the bilinear height sampler: widths, codes, pipeline types
// and the remainder step shared by the sampler's wrap pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bhs_pkg;

    localparam int SIDE_BITS = 6;
    localparam int MAX_SIDE  = 1 << SIDE_BITS;
    localparam int ADDR_W    = 2 * SIDE_BITS;
    localparam int CELL_W    = 16;
    localparam int POS_W     = 20;
    localparam int FRAC_BITS = 8;
    localparam int INT_W     = POS_W - FRAC_BITS;
    localparam int REG_W     = SIDE_BITS + 1;
    localparam int WGT_W     = FRAC_BITS + 1;

    localparam logic       OP_WRITE  = 1'b0;
    localparam logic       OP_SAMPLE = 1'b1;
    localparam logic       CFG_MAP_WIDTH  = 1'b0;
    localparam logic       CFG_MAP_HEIGHT = 1'b1;

    typedef struct packed {
        logic                 op;
        logic [SIDE_BITS-1:0] cx;
        logic [SIDE_BITS-1:0] cy;
        logic [CELL_W-1:0]    val;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic [INT_W-1:0]     ax;
        logic [INT_W-1:0]     ay;
        logic                 negx;
        logic                 negy;
        logic [SIDE_BITS-1:0] rx;
        logic [SIDE_BITS-1:0] ry;
    } t_mod_stage;

    // one restoring remainder step: shift in a bit, subtract side if it fits
    function automatic logic [SIDE_BITS-1:0] rem_step(
        input logic [SIDE_BITS-1:0] rem,
        input logic                 b,
        input logic [REG_W-1:0]     side
    );
        logic [REG_W-1:0] t;
        t = {rem, b};
        if (t >= side) begin
            t = t - side;
        end
        return t[SIDE_BITS-1:0];
    endfunction

    function automatic logic [REG_W-1:0] side_of(input logic [REG_W-1:0] r);
        if (r == '0) begin
            return REG_W'(1);
        end else if (r > REG_W'(MAX_SIDE)) begin
            return REG_W'(MAX_SIDE);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bhs_in_if.sv =====
// Input channel of the height sampler: valid/ready plus item fields.
// Depends on bhs_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bhs_in_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [bhs_pkg::SIDE_BITS-1:0]       cell_x;
    logic [bhs_pkg::SIDE_BITS-1:0]       cell_y;
    logic signed [bhs_pkg::CELL_W-1:0]   cell_value;
    logic signed [bhs_pkg::POS_W-1:0]    pos_x;
    logic signed [bhs_pkg::POS_W-1:0]    pos_y;

    modport source (output valid, opcode, cell_x, cell_y, cell_value, pos_x, pos_y,
                    input ready);
    modport sink (input valid, opcode, cell_x, cell_y, cell_value, pos_x, pos_y,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/bhs_out_if.sv =====
// Result channel of the height sampler: valid/ready plus the height.
// Depends on bhs_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bhs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [bhs_pkg::CELL_W-1:0] height_out;

    modport source (output valid, height_out, input ready);
    modport sink (input valid, height_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/bhs_ram.sv =====
// One copy of the height store: 1 write port, 1 read port, registered read.
// Depends on bhs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bhs_ram (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [bhs_pkg::ADDR_W-1:0]  i_waddr,
    input  wire logic [bhs_pkg::CELL_W-1:0]  i_wdata,
    input  wire logic                        i_re,
    input  wire logic [bhs_pkg::ADDR_W-1:0]  i_raddr,
    output logic      [bhs_pkg::CELL_W-1:0]  o_rdata
);
    logic [bhs_pkg::CELL_W-1:0] r_mem [bhs_pkg::MAX_SIDE*bhs_pkg::MAX_SIDE];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/bilinear_height_sampler_wrap.sv =====
// Top level of the bilinear height sampler with wrap-around addressing.
// Depends on bhs_pkg, bhs_in_if, bhs_out_if and bhs_ram.
//
// Accepts one transaction per clock, write or sample, and delivers one height per
// sample through a one-bit-per-stage remainder pipeline for each coordinate, the
// registered store read, and registers for multiply, add, multiply and rounding.
// The store is held in four copies of a 4096-entry RAM, one per corner, so all four
// corners are read in parallel; writes go to all copies at the read stage, which
// keeps writes and samples in order. The whole pipeline stalls while the result
// register is full and not taken. The store has no reset; every cell in use must
// be written before it is sampled.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_height_sampler_wrap (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    bhs_in_if.sink                             i_sample,
    bhs_out_if.source                          o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [bhs_pkg::REG_W-1:0]     i_cfg_data
);
    localparam int NST = bhs_pkg::INT_W;
    localparam int SB  = bhs_pkg::SIDE_BITS;
    localparam int FB  = bhs_pkg::FRAC_BITS;
    localparam int CW  = bhs_pkg::CELL_W;
    localparam int WW  = bhs_pkg::WGT_W;
    localparam int PW  = CW + WW + 1;
    localparam int RW  = PW + 1;
    localparam int QW  = RW + WW + 1;
    localparam int SW  = QW + 1;

    logic [bhs_pkg::REG_W-1:0] r_width, r_height;
    logic [bhs_pkg::REG_W-1:0] w_eff, h_eff;
    logic adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bhs_pkg::REG_W'(bhs_pkg::MAX_SIDE);
            r_height <= bhs_pkg::REG_W'(bhs_pkg::MAX_SIDE);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bhs_pkg::CFG_MAP_WIDTH:  r_width  <= i_cfg_data;
                bhs_pkg::CFG_MAP_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff = bhs_pkg::side_of(r_width);
    assign h_eff = bhs_pkg::side_of(r_height);

    // ---------------- remainder pipeline ----------------
    logic                r_vld [NST+1];
    bhs_pkg::t_mod_stage r_m   [NST+1];
    bhs_pkg::t_mod_stage n_m   [NST+1];
    logic signed [NST-1:0] ipx, ipy;

    assign adv = !o_result.valid || o_result.ready;
    assign i_sample.ready = adv;

    always_comb begin
        ipx = i_sample.pos_x[bhs_pkg::POS_W-1:FB];
        ipy = i_sample.pos_y[bhs_pkg::POS_W-1:FB];
        n_m[0].op   = i_sample.opcode;
        n_m[0].cx   = i_sample.cell_x;
        n_m[0].cy   = i_sample.cell_y;
        n_m[0].val  = i_sample.cell_value;
        n_m[0].fx   = i_sample.pos_x[FB-1:0];
        n_m[0].fy   = i_sample.pos_y[FB-1:0];
        n_m[0].negx = ipx[NST-1];
        n_m[0].negy = ipy[NST-1];
        n_m[0].ax   = ipx[NST-1] ? (~ipx + NST'(1)) : ipx;
        n_m[0].ay   = ipy[NST-1] ? (~ipy + NST'(1)) : ipy;
        n_m[0].rx   = '0;
        n_m[0].ry   = '0;
        for (int k = 0; k < NST; k++) begin
            n_m[k+1]    = r_m[k];
            n_m[k+1].rx = bhs_pkg::rem_step(r_m[k].rx, r_m[k].ax[NST-1-k], w_eff);
            n_m[k+1].ry = bhs_pkg::rem_step(r_m[k].ry, r_m[k].ay[NST-1-k], h_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= i_sample.valid;
            for (int k = 0; k < NST; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k <= NST; k++) begin
                r_m[k] <= n_m[k];
            end
        end
    end

    // ---------------- address and store access ----------------
    bhs_pkg::t_mod_stage     last;
    logic [SB-1:0]           x0, y0, x1, y1;
    logic [bhs_pkg::REG_W-1:0] xp, yp;
    logic                    do_wr, do_rd;
    logic [bhs_pkg::ADDR_W-1:0] waddr;
    logic [bhs_pkg::ADDR_W-1:0] raddr [4];
    logic [CW-1:0]           q [4];

    always_comb begin
        last = r_m[NST];
        x0 = (last.negx && last.rx != '0) ? SB'(w_eff - {1'b0, last.rx}) : last.rx;
        y0 = (last.negy && last.ry != '0) ? SB'(h_eff - {1'b0, last.ry}) : last.ry;
        xp = {1'b0, x0} + bhs_pkg::REG_W'(1);
        yp = {1'b0, y0} + bhs_pkg::REG_W'(1);
        x1 = (xp == w_eff) ? '0 : xp[SB-1:0];
        y1 = (yp == h_eff) ? '0 : yp[SB-1:0];
        do_wr = adv && r_vld[NST] && (last.op == bhs_pkg::OP_WRITE);
        do_rd = adv && r_vld[NST] && (last.op == bhs_pkg::OP_SAMPLE);
        waddr = {last.cy, last.cx};
        raddr[0] = {y0, x0};
        raddr[1] = {y0, x1};
        raddr[2] = {y1, x0};
        raddr[3] = {y1, x1};
    end

    for (genvar g = 0; g < 4; g++) begin : g_ram
        bhs_ram u_ram (
            .i_clk   (i_clk),
            .i_we    (do_wr),
            .i_waddr (waddr),
            .i_wdata (last.val),
            .i_re    (do_rd),
            .i_raddr (raddr[g]),
            .o_rdata (q[g])
        );
    end

    // ---------------- blend ----------------
    logic          r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    logic [FB-1:0] r_a_fx, r_a_fy, r_b_fy, r_c_fy;
    logic [WW-1:0] gxa, gyc;
    logic signed [PW-1:0] r_p [4];
    logic signed [RW-1:0] r_r0, r_r1;
    logic signed [QW-1:0] r_q0, r_q1;
    logic signed [SW-1:0] sum;
    logic signed [SW-FB*2-1:0] res;
    logic signed [CW-1:0] n_out;

    assign gxa = WW'(1 << FB) - {1'b0, r_a_fx};
    assign gyc = WW'(1 << FB) - {1'b0, r_c_fy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= do_rd;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_fx <= last.fx;
            r_a_fy <= last.fy;
            r_p[0] <= PW'($signed(q[0])) * $signed(PW'(gxa));
            r_p[1] <= PW'($signed(q[1])) * $signed(PW'(r_a_fx));
            r_p[2] <= PW'($signed(q[2])) * $signed(PW'(gxa));
            r_p[3] <= PW'($signed(q[3])) * $signed(PW'(r_a_fx));
            r_b_fy <= r_a_fy;
            r_r0   <= RW'(r_p[0]) + RW'(r_p[1]);
            r_r1   <= RW'(r_p[2]) + RW'(r_p[3]);
            r_c_fy <= r_b_fy;
            r_q0   <= QW'(r_r0) * $signed(QW'(gyc));
            r_q1   <= QW'(r_r1) * $signed(QW'(r_c_fy));
        end
    end

    always_comb begin
        sum = SW'(r_q0) + SW'(r_q1) + SW'(1 << (2 * FB - 1));
        res = (SW-FB*2)'(sum >>> (2 * FB));
        if (res > (SW-FB*2)'(32767)) begin
            n_out = 16'sh7FFF;
        end else if (res < -(SW-FB*2)'(32768)) begin
            n_out = 16'sh8000;
        end else begin
            n_out = CW'(res);
        end
    end

    logic r_o_vld;
    logic signed [CW-1:0] r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (adv) begin
            r_o_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_data <= n_out;
        end
    end

    assign o_result.valid      = r_o_vld;
    assign o_result.height_out = r_o_data;
endmodule
`default_nettype wire

// ===== rtl/bhs_checker.sv =====
// Port-level checks for the height sampler top level, bound to it below.
// Depends on bilinear_height_sampler_wrap.
`timescale 1ns / 1ps
`default_nettype none
module bhs_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind bilinear_height_sampler_wrap bhs_checker u_bhs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for bilinear_height_sampler_wrap: directed and random write
// and sample transactions, in-bench height predictor, in-order result compare.
// Depends on bhs_pkg, bhs_in_if, bhs_out_if and the sampler RTL.
`timescale 1ns / 1ps
module tb;

    typedef struct {
        logic                                    op;
        logic [bhs_pkg::SIDE_BITS-1:0]           cx;
        logic [bhs_pkg::SIDE_BITS-1:0]           cy;
        logic signed [bhs_pkg::CELL_W-1:0]       val;
        logic signed [bhs_pkg::POS_W-1:0]        px;
        logic signed [bhs_pkg::POS_W-1:0]        py;
    } t_xact;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        cfg_we;
    logic                        cfg_idx;
    logic [bhs_pkg::REG_W-1:0]   cfg_data;

    bhs_in_if  in_ch();
    bhs_out_if out_ch();

    bilinear_height_sampler_wrap i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (in_ch),
        .o_result   (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    t_xact                             pending_q[$];
    logic signed [bhs_pkg::CELL_W-1:0] height_exp_q[$];
    logic signed [bhs_pkg::CELL_W-1:0] heights[bhs_pkg::MAX_SIDE*bhs_pkg::MAX_SIDE];
    bit                                loaded[bhs_pkg::MAX_SIDE*bhs_pkg::MAX_SIDE];
    logic [bhs_pkg::REG_W-1:0]         map_w_reg;
    logic [bhs_pkg::REG_W-1:0]         map_h_reg;
    int                                errors;
    int                                gap_left;
    int                                stall_left;
    int                                idle_cycles;
    int                                hold_reqs;
    int                                hold_seen;
    bit                                calm;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int eff_side(logic [bhs_pkg::REG_W-1:0] r);
        if (r == 0) return 1;
        if (r > bhs_pkg::MAX_SIDE) return bhs_pkg::MAX_SIDE;
        return int'(r);
    endfunction

    function automatic int wrap_cell(logic signed [bhs_pkg::POS_W-1:0] p, int n);
        int ip;
        int m;
        ip = int'(p) >>> bhs_pkg::FRAC_BITS;
        m  = ip % n;
        if (m < 0) m += n;
        return m;
    endfunction

    function automatic logic signed [bhs_pkg::CELL_W-1:0] blend_height(
        logic signed [bhs_pkg::POS_W-1:0] px, logic signed [bhs_pkg::POS_W-1:0] py);
        int      w, h, x0, y0, x1, y1;
        longint  fx, fy, gx, gy, acc, res;
        w  = eff_side(map_w_reg);
        h  = eff_side(map_h_reg);
        x0 = wrap_cell(px, w);
        y0 = wrap_cell(py, h);
        x1 = (x0 + 1) % w;
        y1 = (y0 + 1) % h;
        fx = longint'(px[bhs_pkg::FRAC_BITS-1:0]);
        fy = longint'(py[bhs_pkg::FRAC_BITS-1:0]);
        gx = (1 << bhs_pkg::FRAC_BITS) - fx;
        gy = (1 << bhs_pkg::FRAC_BITS) - fy;
        acc = longint'(heights[y0*bhs_pkg::MAX_SIDE+x0]) * gx * gy
            + longint'(heights[y0*bhs_pkg::MAX_SIDE+x1]) * fx * gy
            + longint'(heights[y1*bhs_pkg::MAX_SIDE+x0]) * gx * fy
            + longint'(heights[y1*bhs_pkg::MAX_SIDE+x1]) * fx * fy;
        res = (acc + (longint'(1) << (2*bhs_pkg::FRAC_BITS-1))) >>> (2*bhs_pkg::FRAC_BITS);
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        return res[bhs_pkg::CELL_W-1:0];
    endfunction

    task automatic push_write(int x, int y, logic signed [bhs_pkg::CELL_W-1:0] v);
        t_xact t;
        t.op  = bhs_pkg::OP_WRITE;
        t.cx  = bhs_pkg::SIDE_BITS'(x);
        t.cy  = bhs_pkg::SIDE_BITS'(y);
        t.val = v;
        t.px  = bhs_pkg::POS_W'($urandom);
        t.py  = bhs_pkg::POS_W'($urandom);
        heights[y*bhs_pkg::MAX_SIDE+x] = v;
        loaded[y*bhs_pkg::MAX_SIDE+x]  = 1'b1;
        pending_q.push_back(t);
    endtask

    // loads any corner that has never been written before queueing the sample
    task automatic push_sample(logic signed [bhs_pkg::POS_W-1:0] px,
                               logic signed [bhs_pkg::POS_W-1:0] py);
        t_xact t;
        int    w, h, x0, y0, xs[2], ys[2];
        w  = eff_side(map_w_reg);
        h  = eff_side(map_h_reg);
        x0 = wrap_cell(px, w);
        y0 = wrap_cell(py, h);
        xs[0] = x0; xs[1] = (x0 + 1) % w;
        ys[0] = y0; ys[1] = (y0 + 1) % h;
        for (int j = 0; j < 2; j++)
            for (int i = 0; i < 2; i++)
                if (!loaded[ys[j]*bhs_pkg::MAX_SIDE+xs[i]])
                    push_write(xs[i], ys[j], bhs_pkg::CELL_W'($urandom));
        t.op  = bhs_pkg::OP_SAMPLE;
        t.cx  = bhs_pkg::SIDE_BITS'($urandom);
        t.cy  = bhs_pkg::SIDE_BITS'($urandom);
        t.val = bhs_pkg::CELL_W'($urandom);
        t.px  = px;
        t.py  = py;
        pending_q.push_back(t);
        height_exp_q.push_back(blend_height(px, py));
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || height_exp_q.size() != 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [bhs_pkg::REG_W-1:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == bhs_pkg::CFG_MAP_WIDTH) map_w_reg = v;
        else map_h_reg = v;
    endtask

    task automatic random_phase(int n);
        int start;
        int w, h;
        start = pending_q.size();
        w = eff_side(map_w_reg);
        h = eff_side(map_h_reg);
        while (pending_q.size() - start < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2: push_write($urandom_range(0, bhs_pkg::MAX_SIDE-1),
                                    $urandom_range(0, bhs_pkg::MAX_SIDE-1),
                                    bhs_pkg::CELL_W'($urandom));
                3, 4: push_sample(bhs_pkg::POS_W'($urandom), bhs_pkg::POS_W'($urandom));
                default: push_sample(
                    bhs_pkg::POS_W'((($urandom_range(0, 3*w) - w) << bhs_pkg::FRAC_BITS)
                                    | $urandom_range(0, 255)),
                    bhs_pkg::POS_W'((($urandom_range(0, 3*h) - h) << bhs_pkg::FRAC_BITS)
                                    | $urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        int wset[6];
        int hset[6];
        errors    = 0;
        calm      = 1'b0;
        hold_reqs = 0;
        map_w_reg = bhs_pkg::REG_W'(bhs_pkg::MAX_SIDE);
        map_h_reg = bhs_pkg::REG_W'(bhs_pkg::MAX_SIDE);
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = bhs_pkg::CFG_MAP_WIDTH;
        cfg_data  = '0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = bhs_pkg::OP_WRITE;
        in_ch.cell_x     = '0;
        in_ch.cell_y     = '0;
        in_ch.cell_value = '0;
        in_ch.pos_x      = '0;
        in_ch.pos_y      = '0;
        out_ch.ready     = 1'b0;
        for (int i = 0; i < bhs_pkg::MAX_SIDE*bhs_pkg::MAX_SIDE; i++) loaded[i] = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of values and positions at the reset map size
        push_write(0, 0, 16'sh7fff);
        push_write(63, 63, 16'sh8000);
        push_write(63, 0, 16'sh7fff);
        push_write(0, 63, 16'sh8000);
        push_sample(20'sh00000, 20'sh00000);
        push_sample(20'sh7ffff, 20'sh7ffff);
        push_sample(20'sh80000, 20'sh80000);
        push_sample(20'shfffff, 20'shfffff);
        push_sample(20'sh03f80, 20'sh03f80);
        push_sample(20'sh04000, 20'shfc000);
        push_sample(20'sh000ff, 20'sh0ff01);
        push_sample(20'shfff80, 20'sh00080);
        push_sample(20'sh03fff, 20'sh00000);
        push_sample(20'sh00000, 20'sh03fff);
        drain();

        wset = '{1, 0, 5, 64, 127, 37};
        hset = '{1, 127, 3, 1, 0, 64};
        random_phase(220);
        for (int p = 0; p < 6; p++) begin
            write_reg(bhs_pkg::CFG_MAP_WIDTH, bhs_pkg::REG_W'(wset[p]));
            write_reg(bhs_pkg::CFG_MAP_HEIGHT, bhs_pkg::REG_W'(hset[p]));
            if (p == 2) begin
                hold_reqs <= hold_reqs + 1;
                random_phase(120);
                drain();
                push_sample(20'sh00080, 20'shfff7f);
                push_sample(bhs_pkg::POS_W'($urandom), bhs_pkg::POS_W'($urandom));
            end
            if (p == 5) calm = 1'b1;
            random_phase(200);
        end
        drain();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) begin
        t_xact t;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap_left    = 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                if (!calm && $urandom_range(0, 15) == 0) begin
                    gap_left = $urandom_range(0, 18);
                    in_ch.valid <= 1'b0;
                end else begin
                    t = pending_q.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.opcode     <= t.op;
                    in_ch.cell_x     <= t.cx;
                    in_ch.cell_y     <= t.cy;
                    in_ch.cell_value <= t.val;
                    in_ch.pos_x      <= t.px;
                    in_ch.pos_y      <= t.py;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        logic signed [bhs_pkg::CELL_W-1:0] want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   = 0;
            hold_seen    = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (height_exp_q.size() == 0) begin
                    $error("unexpected result transaction: height_out %0d", out_ch.height_out);
                    errors++;
                end else begin
                    want = height_exp_q.pop_front();
                    if (out_ch.height_out !== want) begin
                        $error("height_out mismatch: expected %0d, actual %0d",
                               want, out_ch.height_out);
                        errors++;
                    end
                end
            end
            if (hold_seen != hold_reqs) begin
                hold_seen  = hold_reqs;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(0, 18);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 5000) begin
            $display("simulation failed");
            $finish;
        end
    end
endmodule

// ===== sim.f =====
rtl/bhs_pkg.sv
rtl/bhs_in_if.sv
rtl/bhs_out_if.sv
rtl/bhs_ram.sv
rtl/bilinear_height_sampler_wrap.sv
rtl/bhs_checker.sv
tb/sv/tb.sv
